// ===== hw/rtl/mbru_pkg.sv =====
`default_nettype none

package mbru_pkg;

   // request kinds, as carried on req_tuser
   typedef enum logic [2:0] {
      KIND_BRA    = 3'd0,
      KIND_BSR    = 3'd1,
      KIND_BCC    = 3'd2,
      KIND_DBCC   = 3'd3,
      KIND_SCC    = 3'd4,
      KIND_TRAPCC = 3'd5,
      KIND_NONE   = 3'd6
   } kind_type;

   // condition groups, opcode bits 11:9; bit 8 picks the true or inverted sense
   localparam logic [2:0] CC_GRP_T  = 3'd0;
   localparam logic [2:0] CC_GRP_HI = 3'd1;
   localparam logic [2:0] CC_GRP_CC = 3'd2;
   localparam logic [2:0] CC_GRP_NE = 3'd3;
   localparam logic [2:0] CC_GRP_VC = 3'd4;
   localparam logic [2:0] CC_GRP_PL = 3'd5;
   localparam logic [2:0] CC_GRP_GE = 3'd6;
   localparam logic [2:0] CC_GRP_GT = 3'd7;

   // byte displacement codes that select extension words
   localparam logic [7:0] DISP_WORD = 8'h00;
   localparam logic [7:0] DISP_LONG = 8'hFF;

   // TRAPcc operand modes, opcode bits 2:0
   localparam logic [2:0] TRAP_MODE_WORD = 3'd2;
   localparam logic [2:0] TRAP_MODE_LONG = 3'd3;
   localparam logic [2:0] TRAP_MODE_NONE = 3'd4;

   localparam logic [31:0] STACK_PUSH_BYTES = 32'd4;
   localparam logic [15:0] COUNTER_EXPIRED  = 16'hFFFF;
   localparam logic [7:0]  SET_TRUE         = 8'hFF;
   localparam logic [7:0]  SET_FALSE        = 8'h00;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 160;

   typedef struct packed {
      logic [15:0] opcode;
      logic [31:0] ext_words;
      logic [31:0] pc_next;
      logic        flag_n;
      logic        flag_z;
      logic        flag_v;
      logic        flag_c;
      logic [15:0] counter_in;
      logic [31:0] stack_ptr;
   } instr_type;

   // classified instruction, front to back
   typedef struct packed {
      kind_type    kind;
      logic        cond;
      logic [31:0] disp;
      logic [1:0]  words;
      logic        trap;
      logic        illegal;
      logic [31:0] pc_next;
      logic [15:0] counter_in;
      logic [31:0] stack_ptr;
   } entry_type;

   typedef struct packed {
      logic        branch_taken;
      logic [31:0] target_pc;
      logic        address_error;
      logic [31:0] fault_addr;
      logic [15:0] counter_out;
      logic        push_return;
      logic [31:0] return_addr;
      logic [31:0] stack_ptr_out;
      logic [7:0]  set_byte;
      logic        trap_taken;
      logic        illegal;
      logic [1:0]  words_used;
   } result_type;

   function automatic logic cond_holds(input logic [3:0] cc, input logic n,
                                       input logic z, input logic v, input logic c);
      logic base;
      unique case (cc[3:1])
         CC_GRP_T:  base = 1'b0;
         CC_GRP_HI: base = c | z;
         CC_GRP_CC: base = c;
         CC_GRP_NE: base = z;
         CC_GRP_VC: base = v;
         CC_GRP_PL: base = n;
         CC_GRP_GE: base = n ^ v;
         CC_GRP_GT: base = (n ^ v) | z;
         default:   base = 1'b0;
      endcase
      return cc[0] ? base : ~base;
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

   function automatic logic [31:0] sext8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbru_front.sv =====
`default_nettype none

module mbru_front
   import mbru_pkg::*;
(
   input  wire logic [2:0] req_kind,
   input  instr_type       instr,
   output entry_type       entry
);

   kind_type    kind;
   logic        cond;
   logic [7:0]  d8;
   logic [15:0] ext1;

   assign d8   = instr.opcode[7:0];
   assign ext1 = instr.ext_words[31:16];
   assign kind = (req_kind > KIND_TRAPCC) ? KIND_NONE : kind_type'(req_kind);
   assign cond = cond_holds(instr.opcode[11:8], instr.flag_n, instr.flag_z,
                            instr.flag_v, instr.flag_c);

   always_comb begin
      entry            = '0;
      entry.kind       = kind;
      entry.cond       = cond;
      entry.pc_next    = instr.pc_next;
      entry.counter_in = instr.counter_in;
      entry.stack_ptr  = instr.stack_ptr;
      entry.disp       = sext16(ext1);
      unique case (kind)
         KIND_BRA, KIND_BSR, KIND_BCC: begin
            priority if (d8 == DISP_WORD) begin
               entry.disp  = sext16(ext1);
               entry.words = 2'd1;
            end else if (d8 == DISP_LONG) begin
               entry.disp  = instr.ext_words;
               entry.words = 2'd2;
            end else begin
               entry.disp  = sext8(d8);
            end
         end
         KIND_DBCC: begin
            entry.words = 2'd1;
         end
         KIND_TRAPCC: begin
            unique case (instr.opcode[2:0])
               TRAP_MODE_WORD: begin
                  entry.words = 2'd1;
                  entry.trap  = cond;
               end
               TRAP_MODE_LONG: begin
                  entry.words = 2'd2;
                  entry.trap  = cond;
               end
               TRAP_MODE_NONE: begin
                  entry.trap  = cond;
               end
               default: begin
                  entry.illegal = 1'b1;
               end
            endcase
         end
         KIND_SCC, KIND_NONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mbru_queue.sv =====
`default_nettype none

module mbru_queue
   import mbru_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   output logic      wr_ready,
   input  entry_type wr_data,
   output logic      rd_valid,
   input  wire logic rd_ready,
   output entry_type rd_data
);

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     push, pop;

   assign wr_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entries_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      wr_ptr_in = push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mbru_back.sv =====
`default_nettype none

module mbru_back
   import mbru_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic op_valid,
   output logic      op_ready,
   input  entry_type op,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output result_type rsp
);

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic [31:0] target, fall_through, sp_dec;
   logic [15:0] cnt_dec;
   logic        taken;

   assign op_ready  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign target       = op.pc_next + op.disp;
   assign fall_through = op.pc_next + {29'd0, op.words, 1'b0};
   assign sp_dec       = op.stack_ptr - STACK_PUSH_BYTES;
   assign cnt_dec      = op.counter_in - 16'd1;

   always_comb begin
      rsp_in               = '0;
      rsp_in.counter_out   = op.counter_in;
      rsp_in.stack_ptr_out = op.stack_ptr;
      rsp_in.trap_taken    = op.trap;
      rsp_in.illegal       = op.illegal;
      rsp_in.words_used    = op.words;
      taken                = 1'b0;
      unique case (op.kind)
         KIND_BRA: begin
            taken = 1'b1;
         end
         KIND_BSR: begin
            taken                = 1'b1;
            rsp_in.push_return   = 1'b1;
            rsp_in.return_addr   = fall_through;
            rsp_in.stack_ptr_out = sp_dec;
         end
         KIND_BCC: begin
            taken = op.cond;
         end
         KIND_DBCC: begin
            // condition false: decrement, loop until the counter wraps to -1
            if (!op.cond) begin
               rsp_in.counter_out = cnt_dec;
               taken              = (cnt_dec != COUNTER_EXPIRED);
            end
         end
         KIND_SCC: begin
            rsp_in.set_byte = op.cond ? SET_TRUE : SET_FALSE;
         end
         KIND_TRAPCC, KIND_NONE: begin
         end
         default: begin
         end
      endcase
      rsp_in.branch_taken  = taken;
      rsp_in.target_pc     = taken ? target : fall_through;
      rsp_in.address_error = taken & target[0];
      rsp_in.fault_addr    = (taken & target[0]) ? {target[31:1], 1'b0} : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op_ready) begin
         rsp_valid_in = op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_valid && op_ready) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/m68k_branch_resolve_unit_core.sv =====
`default_nettype none

// Branch resolve unit for 68000-family flow instructions (BRA, BSR, Bcc, DBcc,
// Scc, TRAPcc). Each request word yields exactly one response word. The front
// decodes the kind, evaluates the condition from N/Z/V/C and picks the
// displacement and extension word count; a two-entry queue feeds the back,
// which forms the target, fall-through, return address, stack pointer and
// counter and holds the result in an output register. Throughput is one word
// per clock as long as the response side takes words; an accepted request
// passes through a queue slot and then the output register on its way to the
// response. A stalled response side backs up into the queue, and req_tready
// drops once both queue entries are full.

module m68k_branch_resolve_unit_core
   import mbru_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // opcode, ext_words, pc_next, flag_n, flag_z, flag_v, flag_c, counter_in,
   // stack_ptr, zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // request kind (kind_type)
   input  wire logic [2:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // branch_taken, target_pc, address_error, fault_addr, counter_out,
   // push_return, return_addr, stack_ptr_out, set_byte, trap_taken, illegal,
   // words_used, zero pad
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   instr_type  instr;
   entry_type  front_entry, back_entry;
   logic       back_valid, back_ready;
   result_type rsp;

   assign instr.opcode     = req_tdata[15:0];
   assign instr.ext_words  = req_tdata[47:16];
   assign instr.pc_next    = req_tdata[79:48];
   assign instr.flag_n     = req_tdata[80];
   assign instr.flag_z     = req_tdata[81];
   assign instr.flag_v     = req_tdata[82];
   assign instr.flag_c     = req_tdata[83];
   assign instr.counter_in = req_tdata[99:84];
   assign instr.stack_ptr  = req_tdata[131:100];

   mbru_front u_front (
      .req_kind (req_tuser),
      .instr    (instr),
      .entry    (front_entry)
   );

   mbru_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (front_entry),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_data  (back_entry)
   );

   mbru_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (back_valid),
      .op_ready  (back_ready),
      .op        (back_entry),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.words_used, rsp.illegal, rsp.trap_taken,
                       rsp.set_byte, rsp.stack_ptr_out, rsp.return_addr,
                       rsp.push_return, rsp.counter_out, rsp.fault_addr,
                       rsp.address_error, rsp.target_pc, rsp.branch_taken};

endmodule

`default_nettype wire

// ===== hw/rtl/mbru_checker.sv =====
`default_nettype none

module mbru_checker
   import mbru_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // rsp_tdata: [0] taken, [32:1] target, [33] aerr, [65:34] fault,
   // [82] push, [155] trap, [156] illegal, [158:157] words

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   a_aerr_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |->
         rsp_tdata[0] && rsp_tdata[1] && rsp_tdata[65:35] == rsp_tdata[32:2]
         && !rsp_tdata[34])
      else $error("address error without an odd taken target");

   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[156] |->
         !rsp_tdata[155] && !rsp_tdata[0] && !rsp_tdata[82]
         && rsp_tdata[158:157] == 2'd0)
      else $error("illegal TRAPcc with side effects");

endmodule

bind m68k_branch_resolve_unit_core mbru_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
